// ----- design/ffs_pkg.sv -----
package ffs_pkg;

  localparam int CW = 12;

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic signed [CW-1:0] third_z;
  } in_item_t;

  typedef struct packed {
    logic [23:0] shaded_color;
    logic [16:0] intensity;
    logic        degenerate;
  } out_item_t;

  localparam int NW = 2 * CW + 3;
  localparam int SW = 2 * NW + 2;

  // Work handed from the front to the back: squared normal terms.
  typedef struct packed {
    logic [SW-1:0] z2;
    logic [SW-1:0] s;
  } face_t;

  localparam int QD = 4;
  localparam int PW = $clog2(QD);
  localparam int DIV_STEPS = 33;
  localparam int SQ_STEPS = 18;

endpackage

// ----- design/flat_face_shading.sv -----
// Path: 4 front stages, a queue write, then the back stages.
// Throughput: one triangle per cycle while no stall holds it; the divider
// and square root are bit-per-stage pipelines, so independent faces follow
// back to back.
// Reset: synchronous active-low rst_n clears all valid state and sets
// color_r to 0xFFFFFF.
module flat_face_shading (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);

  // The front forms the normal and its squared length; the queue decouples it
  // from the back, which divides, takes the root and scales the color.
  // An output stall freezes the back; the four-entry queue then fills and
  // only when it is full does the input side see a stall.
  logic           f_valid, f_stall, q_valid, q_take;
  ffs_pkg::face_t f_data, q_data;
  logic [23:0]    color_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) color_r <= 24'hFFFFFF;
    else if (cfg_valid && cfg_ready) color_r <= cfg_data;
  end

  ffs_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_data,
                     .f_valid, .f_stall, .f_data);
  ffs_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall),
                     .wr_data(f_data), .rd_valid(q_valid), .rd_take(q_take),
                     .rd_data(q_data));
  ffs_back u_back (.clk, .rst_n, .b_valid(q_valid), .b_take(q_take), .b_data(q_data),
                   .color(color_r), .out_valid, .out_stall, .out_data);

  // Checks that a degenerate result always carries zero color.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.shaded_color == '0)
    else $error("degenerate color");
  // Intensity never exceeds one.
  a_g: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.intensity <= 17'd65536)
    else $error("intensity range");

endmodule

// ----- design/ffs_front.sv -----
module ffs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffs_pkg::in_item_t in_data,
  output logic             f_valid,
  input  logic             f_stall,
  output ffs_pkg::face_t   f_data
);

  localparam int CW = ffs_pkg::CW;
  localparam int EW = CW + 1;
  localparam int NW = ffs_pkg::NW;
  localparam int SW = ffs_pkg::SW;

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [EW-1:0] e0x_r, e0y_r, e0z_r, e1x_r, e1y_r, e1z_r;
  logic signed [2*EW-1:0] p_r [6];
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic [SW-1:0]        z2_r, s_r;
  logic [SW-1:0]        sq_x, sq_y, sq_z;
  logic                 adv;

  assign adv      = !f_stall;
  assign in_stall = f_stall;
  assign f_valid  = v4_r;
  assign f_data   = '{z2: z2_r, s: s_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0x_r <= EW'(in_data.third_x) - EW'(in_data.first_x);
      e0y_r <= EW'(in_data.third_y) - EW'(in_data.first_y);
      e0z_r <= EW'(in_data.third_z) - EW'(in_data.first_z);
      e1x_r <= EW'(in_data.second_x) - EW'(in_data.first_x);
      e1y_r <= EW'(in_data.second_y) - EW'(in_data.first_y);
      e1z_r <= EW'(in_data.second_z) - EW'(in_data.first_z);
      p_r[0] <= e0y_r * e1z_r;
      p_r[1] <= e1y_r * e0z_r;
      p_r[2] <= e1x_r * e0z_r;
      p_r[3] <= e0x_r * e1z_r;
      p_r[4] <= e0x_r * e1y_r;
      p_r[5] <= e1x_r * e0y_r;
      nx_r <= NW'(p_r[0]) - NW'(p_r[1]);
      ny_r <= NW'(p_r[2]) - NW'(p_r[3]);
      nz_r <= NW'(p_r[4]) - NW'(p_r[5]);
    end
  end

  // Squares are taken on the stage after the normal, tracked by v4_r.
  always_comb begin
    sq_x = SW'(nx_r * nx_r);
    sq_y = SW'(ny_r * ny_r);
    sq_z = SW'(nz_r * nz_r);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      z2_r <= sq_z;
      s_r  <= sq_x + sq_y + sq_z;
    end
  end

endmodule

// ----- design/ffs_queue.sv -----
module ffs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  ffs_pkg::face_t wr_data,
  output logic           rd_valid,
  input  logic           rd_take,
  output ffs_pkg::face_t rd_data
);

  localparam int QD = ffs_pkg::QD;
  localparam int PW = ffs_pkg::PW;

  ffs_pkg::face_t mem_r [QD];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;
  logic           wr, rd;

  // The front freezes as a whole on stall, so only a full queue holds it.
  assign wr_stall = cnt_r == (PW+1)'(QD);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- design/ffs_back.sv -----
module ffs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              b_valid,
  output logic              b_take,
  input  ffs_pkg::face_t    b_data,
  input  logic [23:0]       color,
  output logic              out_valid,
  input  logic              out_stall,
  output ffs_pkg::out_item_t out_data
);

  localparam int SW = ffs_pkg::SW;
  localparam int DN = ffs_pkg::DIV_STEPS;
  localparam int QN = ffs_pkg::SQ_STEPS;
  localparam int NS = DN + QN + 3;

  // Pipelined restoring divider then pipelined square root, one bit per stage.
  logic          vld_r [NS];
  logic          dg_r  [NS];
  logic [SW:0]   rem_r [DN];
  logic [SW-1:0] den_r [DN];
  logic [31:0]   q_r   [DN];
  logic [33:0]   sn_r  [QN];
  logic [33:0]   sr_r  [QN];
  logic [16:0]   f_r, g_r, g2_r;
  logic [23:0]   col_r;
  logic          adv;

  assign adv    = !(out_valid && out_stall);
  assign b_take = adv && b_valid;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= b_valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [SW:0] t;
    logic [33:0] tr;
    logic        full;
    if (adv) begin
      dg_r[0]  <= b_data.s == '0;
      for (int i = 1; i < NS; i++) dg_r[i] <= dg_r[i-1];
      rem_r[0] <= {1'b0, b_data.z2};
      den_r[0] <= b_data.s;
      q_r[0]   <= '0;
      for (int i = 1; i < DN; i++) begin
        t = rem_r[i-1] - {1'b0, den_r[i-1]};
        den_r[i] <= den_r[i-1];
        if (rem_r[i-1] >= {1'b0, den_r[i-1]}) begin
          rem_r[i] <= {t[SW-1:0], 1'b0};
          q_r[i]   <= {q_r[i-1][30:0], 1'b1};
        end else begin
          rem_r[i] <= {rem_r[i-1][SW-1:0], 1'b0};
          q_r[i]   <= {q_r[i-1][30:0], 1'b0};
        end
      end
      full = rem_r[DN-1] >= {1'b0, den_r[DN-1]};
      sn_r[0] <= {1'b0, q_r[DN-1], full};
      sr_r[0] <= '0;
      // Each stage settles one root bit, from bit 16 down to bit 0.
      for (int i = 1; i < QN; i++) begin
        tr = ((sr_r[i-1] << 2) | 34'd1) << (2 * (QN - 1 - i));
        if (sn_r[i-1] >= tr) begin
          sn_r[i] <= sn_r[i-1] - tr;
          sr_r[i] <= (sr_r[i-1] << 1) | 34'd1;
        end else begin
          sn_r[i] <= sn_r[i-1];
          sr_r[i] <= sr_r[i-1] << 1;
        end
      end
      f_r   <= (sr_r[QN-1] > 34'd65536) ? 17'd65536 : sr_r[QN-1][16:0];
      g_r   <= 17'(({17'd0, f_r} * (34'd131072 - {17'd0, f_r})) >> 16);
      g2_r  <= g_r;
      col_r <= 24'(((g_r * color[23:16] + 32'd32768) >> 16) << 16)
             | 24'(((g_r * color[15:8] + 32'd32768) >> 16) << 8)
             | 24'((g_r * color[7:0] + 32'd32768) >> 16);
    end
  end

  assign out_data = dg_r[NS-1]
    ? ffs_pkg::out_item_t'{shaded_color: '0, intensity: '0, degenerate: 1'b1}
    : ffs_pkg::out_item_t'{shaded_color: col_r, intensity: g2_r, degenerate: 1'b0};

endmodule

// ----- tb/ffs_checker.sv -----
module ffs_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ffs_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ffs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [23:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0]        surface_color;
  ffs_pkg::out_item_t shade_queue[$];

  function automatic logic [32:0] norm_ratio(logic [71:0] z2, logic [71:0] s);
    logic [72:0] r;
    logic [32:0] q;
    r = {1'b0, z2};
    q = '0;
    if (z2 >= s) return 33'h1_0000_0000;
    for (int k = 0; k < 32; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, s}) begin
        r = r - {1'b0, s};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] root_floor(logic [32:0] n);
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] mid;
    lo = '0;
    hi = 33'd65537;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (64'(mid) * 64'(mid) <= 64'(n)) lo = mid;
      else hi = mid;
    end
    return lo[31:0];
  endfunction

  function automatic ffs_pkg::out_item_t shade_face(ffs_pkg::in_item_t t, logic [23:0] col);
    ffs_pkg::out_item_t o;
    longint      e0x, e0y, e0z, e1x, e1y, e1z, nx, ny, nz;
    logic [71:0] z2, s;
    logic [63:0] f, g, v;
    e0x = longint'(t.third_x) - longint'(t.first_x);
    e0y = longint'(t.third_y) - longint'(t.first_y);
    e0z = longint'(t.third_z) - longint'(t.first_z);
    e1x = longint'(t.second_x) - longint'(t.first_x);
    e1y = longint'(t.second_y) - longint'(t.first_y);
    e1z = longint'(t.second_z) - longint'(t.first_z);
    nx = e0y * e1z - e1y * e0z;
    ny = e1x * e0z - e0x * e1z;
    nz = e0x * e1y - e1x * e0y;
    z2 = 72'(nz * nz);
    s  = 72'(nx * nx) + 72'(ny * ny) + z2;
    o = '0;
    if (s == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    f = 64'(root_floor(norm_ratio(z2, s)));
    if (f > 65536) f = 65536;
    g = (f * (131072 - f)) >> 16;
    for (int k = 0; k < 3; k++) begin
      v = (g * 64'(col[8*k +: 8]) + 32768) >> 16;
      if (v > 255) v = 255;
      o.shaded_color[8*k +: 8] = v[7:0];
    end
    o.intensity = g[16:0];
    return o;
  endfunction

  always @(posedge clk) begin
    ffs_pkg::out_item_t want;
    if (!rst_n) begin
      surface_color <= 24'hFFFFFF;
      shade_queue.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) surface_color <= cfg_data;
      if (in_valid && !in_stall) shade_queue.push_back(shade_face(in_data, surface_color));
      if (out_valid && !out_stall) begin
        if (shade_queue.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected item %h", out_data);
        end else begin
          want = shade_queue.pop_front();
          if (want !== out_data) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("color exp %h got %h, intensity exp %h got %h, degen exp %b got %b",
                       want.shaded_color, out_data.shaded_color, want.intensity,
                       out_data.intensity, want.degenerate, out_data.degenerate);
          end
        end
      end
      pending <= shade_queue.size();
    end
  end
endmodule

// ----- tb/tb_flat_face_shading.sv -----
module tb_flat_face_shading;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 100;
  localparam int LIMIT = 400000;
  localparam int CW = ffs_pkg::CW;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ffs_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ffs_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [23:0] cfg_data = '0;
  int        errors;
  int        pending;
  int        cycle = 0;
  // While set, both sides run without any random gaps.
  bit        steady = 1'b0;

  always #1 clk = ~clk;

  flat_face_shading DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ffs_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // The result side stalls about a quarter of the time, except in steady stretches.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 26);
  end

  // A watchdog bounds the whole run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("flat_face_shading: mismatch");
      $finish;
    end
  end

  // Offers one triangle, holding it stable until the block takes it.
  // Random gaps before the item exercise the sender side idling; valid is
  // only dropped in a gap, so back-to-back items keep it high.
  task automatic send_face(ffs_pkg::in_item_t t);
    while (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_faces();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The color register is only changed once the pipeline has emptied.
  task automatic set_color(logic [23:0] c);
    drain_faces();
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ffs_pkg::in_item_t make_face(int a[9]);
    ffs_pkg::in_item_t t;
    t.first_x = CW'(a[0]); t.first_y = CW'(a[1]); t.first_z = CW'(a[2]);
    t.second_x = CW'(a[3]); t.second_y = CW'(a[4]); t.second_z = CW'(a[5]);
    t.third_x = CW'(a[6]); t.third_y = CW'(a[7]); t.third_z = CW'(a[8]);
    return t;
  endfunction

  function automatic int pick_coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Random faces: some full range, some small, some flat in z, some degenerate.
  function automatic ffs_pkg::in_item_t random_face();
    ffs_pkg::in_item_t t;
    int a[9];
    int kind;
    int span;
    kind = $urandom_range(9);
    span = (kind < 4) ? 2047 : (kind < 7 ? 8 : 200);
    for (int i = 0; i < 9; i++) a[i] = pick_coord(span);
    if (kind == 0) begin
      for (int i = 0; i < 9; i++) a[i] = int'($urandom_range(4095)) - 2048;
    end
    if (kind == 7) begin
      // Coplanar in z: the normal points straight along z.
      a[5] = a[2];
      a[8] = a[2];
    end
    if (kind == 8) begin
      // Collinear points give a degenerate face.
      a[3] = a[0] + 2; a[4] = a[1] + 2; a[5] = a[2] + 2;
      a[6] = a[0] + 5; a[7] = a[1] + 5; a[8] = a[2] + 5;
    end
    if (kind == 9) begin
      // Coincident vertices.
      a[3] = a[0]; a[4] = a[1]; a[5] = a[2];
    end
    t = make_face(a);
    return t;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed faces under the reset color: extremes, axis normals, degenerate.
    send_face(make_face('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_face(make_face('{-2048, -2048, -2048, 2047, 2047, 2047, 0, 0, 0}));
    send_face(make_face('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send_face(make_face('{-2048, -2048, 5, 2047, -2048, 5, -2048, 2047, 5}));
    send_face(make_face('{0, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_face(make_face('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
    send_face(make_face('{-2048, 2047, -2048, 2047, -2048, 2047, -2048, -2048, 2047}));
    send_face(make_face('{2047, 2047, 2047, -2048, 2047, -2048, 2047, -2048, -2048}));
    send_face(make_face('{0, 0, 0, 1, 1, 1, 2, 2, 2}));
    send_face(make_face('{0, 0, 0, 3, 0, 1, 0, 3, 1}));
    send_face(make_face('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
    send_face(make_face('{0, 0, 0, 2047, 1, 0, 1, 2047, 2047}));

    set_color(24'h000000);
    send_face(make_face('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send_face(make_face('{0, 0, 0, 5, 1, 2, 1, 4, 3}));
    set_color(24'h80FF01);
    send_face(make_face('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send_face(make_face('{0, 0, 0, 5, 1, 2, 1, 4, 3}));
    send_face(make_face('{0, 0, 0, 7, 0, 3, 0, 7, 9}));

    // Random phases, each under a new color; the third runs without gaps.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_color(24'hFFFFFF);
      else if (ph == 4) set_color(24'h000000);
      else set_color(24'($urandom_range(24'hFFFFFF)));
      steady = (ph == 2);
      for (int i = 0; i < 222; i++) send_face(random_face());
      steady = 1'b0;
    end

    drain_faces();
    if (errors == 0) begin
      $display("flat_face_shading: match");
    end else begin
      $display("flat_face_shading: mismatch");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/ffs_pkg.sv
design/ffs_front.sv
design/ffs_queue.sv
design/ffs_back.sv
design/flat_face_shading.sv
tb/ffs_checker.sv
tb/tb_flat_face_shading.sv
